/* rtl/core/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the clock, off while in reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/rvd_pkg.sv */
// Types and codes for the RV64IMC decoder pipeline.
// No dependencies.
package rvd_pkg;

    typedef enum logic [3:0] {
        F_UNK, F_R, F_I, F_S, F_B, F_U, F_J, F_CR, F_CI, F_CSS, F_CIW, F_CL,
        F_CS, F_CB, F_CJ
    } fmt_t;

    typedef enum logic [6:0] {
        O_NONE,
        O_LUI, O_AUIPC, O_JAL, O_JALR, O_BEQ, O_BNE, O_BLT, O_BGE, O_BLTU, O_BGEU,
        O_LB, O_LH, O_LW, O_LD, O_LBU, O_LHU, O_LWU, O_SB, O_SH, O_SW, O_SD,
        O_ADDI, O_SLTI, O_SLTIU, O_XORI, O_ORI, O_ANDI, O_SLLI, O_SRLI, O_SRAI,
        O_ADD, O_SUB, O_SLL, O_SLT, O_SLTU, O_XOR, O_SRL, O_SRA, O_OR, O_AND,
        O_MUL, O_MULH, O_MULHSU, O_MULHU, O_DIV, O_DIVU, O_REM, O_REMU,
        O_ADDIW, O_SLLIW, O_SRLIW, O_SRAIW, O_ADDW, O_SUBW, O_SLLW, O_SRLW, O_SRAW,
        O_MULW, O_DIVW, O_DIVUW, O_REMW, O_REMUW,
        O_FENCE, O_FENCE_I, O_ECALL, O_EBREAK,
        O_C_ADDI4SPN, O_C_LW, O_C_LD, O_C_SW, O_C_SD,
        O_C_NOP, O_C_ADDI, O_C_ADDIW, O_C_JAL, O_C_LI, O_C_ADDI16SP, O_C_LUI,
        O_C_SRLI, O_C_SRAI, O_C_ANDI, O_C_SUB, O_C_XOR, O_C_OR, O_C_AND,
        O_C_SUBW, O_C_ADDW, O_C_J, O_C_BEQZ, O_C_BNEZ,
        O_C_SLLI, O_C_LWSP, O_C_LDSP, O_C_JR, O_C_MV, O_C_EBREAK, O_C_JALR,
        O_C_ADD, O_C_SWSP, O_C_SDSP
    } op_t;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMMW = 7'h1b;
    localparam logic [6:0] OPC_OPW    = 7'h3b;
    localparam logic [6:0] OPC_FENCE  = 7'h0f;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT = 7'h20;
    localparam logic [6:0] F6_ALT64 = 7'h10;

    typedef struct packed {
        logic        valid;
        logic [2:0]  len;
        logic [31:0] raw;
        fmt_t        fmt;
        op_t         op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        hast;
        logic [31:0] off;
    } dec_t;

endpackage

/* rtl/core/rvd_decode.sv */
// Instruction classifier: full-length and compressed decode of one parcel.
// Depends on rvd_pkg.
module rvd_decode (
    input  logic         [31:0] word,
    input  logic         [2:0]  avail,
    input  logic                mode,
    output rvd_pkg::dec_t       dec
);
    import rvd_pkg::*;

    function automatic dec_t put(dec_t d, fmt_t f, op_t o, logic [4:0] rd,
                                 logic [4:0] rs1, logic [4:0] rs2, logic [31:0] imm);
        dec_t r;
        r = d;
        r.valid = 1'b1;
        r.fmt = f;
        r.op = o;
        r.rd = rd;
        r.rs1 = rs1;
        r.rs2 = rs2;
        r.imm = imm;
        return r;
    endfunction

    function automatic dec_t tgt(dec_t d, logic [31:0] off);
        dec_t r;
        r = d;
        r.hast = 1'b1;
        r.off = off;
        return r;
    endfunction

    function automatic op_t ca_op(logic [1:0] f);
        op_t o;
        unique case (f)
            2'd0: o = O_C_SUB;
            2'd1: o = O_C_XOR;
            2'd2: o = O_C_OR;
            default: o = O_C_AND;
        endcase
        return o;
    endfunction

    logic [31:0] w;
    logic [15:0] h;
    logic [6:0]  opc, f7, top, sra_top;
    logic [4:0]  rd, rs1, rs2, crd, crs2, rdp, rs1p;
    logic [2:0]  f3, cf3;
    logic [31:0] immi, imms, immb, immj, sh, ci, joff, lw_off, ld_off, boff;
    logic [31:0] u4spn, u16sp;
    logic [5:0]  six;
    logic        b12;
    logic        ge2, ge4;
    dec_t        full_d, short_d, base;
    op_t         op;

    assign w = word;
    assign h = word[15:0];
    assign ge2 = avail[2] | avail[1];
    assign ge4 = avail[2];

    assign opc = w[6:0];
    assign rd = w[11:7];
    assign f3 = w[14:12];
    assign rs1 = w[19:15];
    assign rs2 = w[24:20];
    assign f7 = w[31:25];
    assign immi = {{20{w[31]}}, w[31:20]};
    assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
    assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign sh = mode ? {26'd0, w[25:20]} : {27'd0, w[24:20]};
    assign top = mode ? {1'b0, w[31:26]} : f7;
    assign sra_top = mode ? F6_ALT64 : F7_ALT;

    assign cf3 = h[15:13];
    assign crd = h[11:7];
    assign crs2 = h[6:2];
    assign rdp = {2'b01, h[4:2]};
    assign rs1p = {2'b01, h[9:7]};
    assign b12 = h[12];
    assign six = {b12, crs2};
    assign ci = {{26{b12}}, six};
    assign joff = {{20{b12}}, b12, h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
    assign lw_off = {25'd0, h[5], h[12:10], h[6], 2'b00};
    assign ld_off = {24'd0, h[6:5], h[12:10], 3'b000};
    assign boff = {{23{b12}}, b12, h[6:5], h[2], h[11:10], h[4:3], 1'b0};
    assign u4spn = {22'd0, h[10:7], h[12:11], h[5], h[6], 2'b00};
    assign u16sp = {{22{b12}}, b12, h[4:3], h[5], h[2], h[6], 4'b0000};

    always_comb
    begin
        base = '0;
        full_d = '0;
        op = O_NONE;
        unique case (opc)
            OPC_LUI:   full_d = put(base, F_U, O_LUI, rd, 5'd0, 5'd0, {12'd0, w[31:12]});
            OPC_AUIPC: full_d = put(base, F_U, O_AUIPC, rd, 5'd0, 5'd0, {12'd0, w[31:12]});
            OPC_JAL:   full_d = tgt(put(base, F_J, O_JAL, rd, 5'd0, 5'd0, immj), immj);
            OPC_JALR:
                if (f3 == 3'd0)
                    full_d = put(base, F_I, O_JALR, rd, rs1, 5'd0, immi);
            OPC_BRANCH:
            begin
                unique case (f3)
                    3'd0: op = O_BEQ;
                    3'd1: op = O_BNE;
                    3'd4: op = O_BLT;
                    3'd5: op = O_BGE;
                    3'd6: op = O_BLTU;
                    3'd7: op = O_BGEU;
                    default: op = O_NONE;
                endcase
                if (op != O_NONE)
                    full_d = tgt(put(base, F_B, op, 5'd0, rs1, rs2, immb), immb);
            end
            OPC_LOAD:
            begin
                unique case (f3)
                    3'd0: op = O_LB;
                    3'd1: op = O_LH;
                    3'd2: op = O_LW;
                    3'd3: op = mode ? O_LD : O_NONE;
                    3'd4: op = O_LBU;
                    3'd5: op = O_LHU;
                    3'd6: op = mode ? O_LWU : O_NONE;
                    default: op = O_NONE;
                endcase
                if (op != O_NONE)
                    full_d = put(base, F_I, op, rd, rs1, 5'd0, immi);
            end
            OPC_STORE:
            begin
                unique case (f3)
                    3'd0: op = O_SB;
                    3'd1: op = O_SH;
                    3'd2: op = O_SW;
                    3'd3: op = mode ? O_SD : O_NONE;
                    default: op = O_NONE;
                endcase
                if (op != O_NONE)
                    full_d = put(base, F_S, op, 5'd0, rs1, rs2, imms);
            end
            OPC_OPIMM:
            begin
                unique case (f3)
                    3'd0: op = O_ADDI;
                    3'd2: op = O_SLTI;
                    3'd3: op = O_SLTIU;
                    3'd4: op = O_XORI;
                    3'd6: op = O_ORI;
                    3'd7: op = O_ANDI;
                    default: op = O_NONE;
                endcase
                if (f3 == 3'd1)
                begin
                    if (top == F7_ZERO)
                        full_d = put(base, F_I, O_SLLI, rd, rs1, 5'd0, sh);
                end
                else if (f3 == 3'd5)
                begin
                    if (top == F7_ZERO)
                        full_d = put(base, F_I, O_SRLI, rd, rs1, 5'd0, sh);
                    else if (top == sra_top)
                        full_d = put(base, F_I, O_SRAI, rd, rs1, 5'd0, sh);
                end
                else
                    full_d = put(base, F_I, op, rd, rs1, 5'd0, immi);
            end
            OPC_OP:
            begin
                if (f7 == F7_MULDIV)
                begin
                    unique case (f3)
                        3'd0: op = O_MUL;
                        3'd1: op = O_MULH;
                        3'd2: op = O_MULHSU;
                        3'd3: op = O_MULHU;
                        3'd4: op = O_DIV;
                        3'd5: op = O_DIVU;
                        3'd6: op = O_REM;
                        default: op = O_REMU;
                    endcase
                end
                else if (f7 == F7_ZERO)
                begin
                    unique case (f3)
                        3'd0: op = O_ADD;
                        3'd1: op = O_SLL;
                        3'd2: op = O_SLT;
                        3'd3: op = O_SLTU;
                        3'd4: op = O_XOR;
                        3'd5: op = O_SRL;
                        3'd6: op = O_OR;
                        default: op = O_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                    op = O_SUB;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    op = O_SRA;
                if (op != O_NONE)
                    full_d = put(base, F_R, op, rd, rs1, rs2, 32'd0);
            end
            OPC_OPIMMW:
            begin
                if (mode)
                begin
                    if (f3 == 3'd0)
                        full_d = put(base, F_I, O_ADDIW, rd, rs1, 5'd0, immi);
                    else if (f3 == 3'd1 && f7 == F7_ZERO)
                        full_d = put(base, F_I, O_SLLIW, rd, rs1, 5'd0, {27'd0, rs2});
                    else if (f3 == 3'd5 && f7 == F7_ZERO)
                        full_d = put(base, F_I, O_SRLIW, rd, rs1, 5'd0, {27'd0, rs2});
                    else if (f3 == 3'd5 && f7 == F7_ALT)
                        full_d = put(base, F_I, O_SRAIW, rd, rs1, 5'd0, {27'd0, rs2});
                end
            end
            OPC_OPW:
            begin
                if (f7 == F7_MULDIV)
                begin
                    unique case (f3)
                        3'd0: op = O_MULW;
                        3'd4: op = O_DIVW;
                        3'd5: op = O_DIVUW;
                        3'd6: op = O_REMW;
                        3'd7: op = O_REMUW;
                        default: op = O_NONE;
                    endcase
                end
                else if (f7 == F7_ZERO && f3 == 3'd0)
                    op = O_ADDW;
                else if (f7 == F7_ZERO && f3 == 3'd1)
                    op = O_SLLW;
                else if (f7 == F7_ZERO && f3 == 3'd5)
                    op = O_SRLW;
                else if (f7 == F7_ALT && f3 == 3'd0)
                    op = O_SUBW;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    op = O_SRAW;
                if (mode && op != O_NONE)
                    full_d = put(base, F_R, op, rd, rs1, rs2, 32'd0);
            end
            OPC_FENCE:
            begin
                if (f3 == 3'd0)
                    full_d = put(base, F_I, O_FENCE, 5'd0, 5'd0, 5'd0,
                                 {24'd0, w[27:24], w[23:20]});
                else if (f3 == 3'd1)
                    full_d = put(base, F_I, O_FENCE_I, 5'd0, 5'd0, 5'd0, 32'd0);
            end
            OPC_SYSTEM:
            begin
                if (f3 == 3'd0 && rs1 == 5'd0 && rd == 5'd0)
                begin
                    if (w[31:20] == 12'd0)
                        full_d = put(base, F_I, O_ECALL, 5'd0, 5'd0, 5'd0, 32'd0);
                    else if (w[31:20] == 12'd1)
                        full_d = put(base, F_I, O_EBREAK, 5'd0, 5'd0, 5'd0, 32'd0);
                end
            end
            default: full_d = '0;
        endcase
    end

    always_comb
    begin
        short_d = '0;
        if (h != 16'd0)
        begin
            unique case (h[1:0])
                2'd0:
                begin
                    unique case (cf3)
                        3'd0:
                            if (u4spn != 32'd0)
                                short_d = put(base, F_CIW, O_C_ADDI4SPN, rdp, 5'd2, 5'd0, u4spn);
                        3'd2: short_d = put(base, F_CL, O_C_LW, rdp, rs1p, 5'd0, lw_off);
                        3'd3:
                            if (mode)
                                short_d = put(base, F_CL, O_C_LD, rdp, rs1p, 5'd0, ld_off);
                        3'd6: short_d = put(base, F_CS, O_C_SW, 5'd0, rs1p, rdp, lw_off);
                        3'd7:
                            if (mode)
                                short_d = put(base, F_CS, O_C_SD, 5'd0, rs1p, rdp, ld_off);
                        default: short_d = '0;
                    endcase
                end
                2'd1:
                begin
                    unique case (cf3)
                        3'd0:
                            if (crd == 5'd0 && six == 6'd0)
                                short_d = put(base, F_CI, O_C_NOP, 5'd0, 5'd0, 5'd0, 32'd0);
                            else if (crd != 5'd0 && six != 6'd0)
                                short_d = put(base, F_CI, O_C_ADDI, crd, crd, 5'd0, ci);
                        3'd1:
                            if (mode)
                            begin
                                if (crd != 5'd0)
                                    short_d = put(base, F_CI, O_C_ADDIW, crd, crd, 5'd0, ci);
                            end
                            else
                                short_d = tgt(put(base, F_CJ, O_C_JAL, 5'd1, 5'd0, 5'd0, joff),
                                              joff);
                        3'd2:
                            if (crd != 5'd0)
                                short_d = put(base, F_CI, O_C_LI, crd, 5'd0, 5'd0, ci);
                        3'd3:
                            if (crd == 5'd2)
                            begin
                                if (u16sp != 32'd0)
                                    short_d = put(base, F_CI, O_C_ADDI16SP, 5'd2, 5'd2, 5'd0,
                                                  u16sp);
                            end
                            else if (crd != 5'd0 && six != 6'd0)
                                short_d = put(base, F_CI, O_C_LUI, crd, 5'd0, 5'd0,
                                              {12'd0, {14{b12}}, six});
                        3'd4:
                        begin
                            if (h[11] == 1'b0)
                            begin
                                if (six != 6'd0 && (mode || !b12))
                                    short_d = put(base, F_CB, h[10] ? O_C_SRAI : O_C_SRLI,
                                                  rs1p, rs1p, 5'd0, {26'd0, six});
                            end
                            else if (h[10] == 1'b0)
                                short_d = put(base, F_CB, O_C_ANDI, rs1p, rs1p, 5'd0, ci);
                            else if (!b12)
                                short_d = put(base, F_CS, ca_op(h[6:5]), rs1p, rs1p, rdp, 32'd0);
                            else if (mode && !h[6])
                                short_d = put(base, F_CS, h[5] ? O_C_ADDW : O_C_SUBW,
                                              rs1p, rs1p, rdp, 32'd0);
                        end
                        3'd5:
                            short_d = tgt(put(base, F_CJ, O_C_J, 5'd0, 5'd0, 5'd0, joff), joff);
                        default:
                            short_d = tgt(put(base, F_CB, (cf3 == 3'd6) ? O_C_BEQZ : O_C_BNEZ,
                                              5'd0, rs1p, 5'd0, boff), boff);
                    endcase
                end
                2'd2:
                begin
                    unique case (cf3)
                        3'd0:
                            if (crd != 5'd0 && six != 6'd0 && (mode || !b12))
                                short_d = put(base, F_CI, O_C_SLLI, crd, crd, 5'd0,
                                              {26'd0, six});
                        3'd2:
                            if (crd != 5'd0)
                                short_d = put(base, F_CI, O_C_LWSP, crd, 5'd2, 5'd0,
                                              {24'd0, h[3:2], b12, h[6:4], 2'b00});
                        3'd3:
                            if (mode && crd != 5'd0)
                                short_d = put(base, F_CI, O_C_LDSP, crd, 5'd2, 5'd0,
                                              {23'd0, h[4:2], b12, h[6:5], 3'b000});
                        3'd4:
                            if (!b12)
                            begin
                                if (crd != 5'd0)
                                begin
                                    if (crs2 == 5'd0)
                                        short_d = put(base, F_CR, O_C_JR, 5'd0, crd, 5'd0, 32'd0);
                                    else
                                        short_d = put(base, F_CR, O_C_MV, crd, 5'd0, crs2, 32'd0);
                                end
                            end
                            else if (crd == 5'd0)
                            begin
                                if (crs2 == 5'd0)
                                    short_d = put(base, F_CR, O_C_EBREAK, 5'd0, 5'd0, 5'd0,
                                                  32'd0);
                            end
                            else if (crs2 == 5'd0)
                                short_d = put(base, F_CR, O_C_JALR, 5'd1, crd, 5'd0, 32'd0);
                            else
                                short_d = put(base, F_CR, O_C_ADD, crd, crd, crs2, 32'd0);
                        3'd6:
                            short_d = put(base, F_CSS, O_C_SWSP, 5'd0, 5'd2, crs2,
                                          {24'd0, h[8:7], h[12:9], 2'b00});
                        3'd7:
                            if (mode)
                                short_d = put(base, F_CSS, O_C_SDSP, 5'd0, 5'd2, crs2,
                                              {23'd0, h[9:7], h[12:10], 3'b000});
                        default: short_d = '0;
                    endcase
                end
                default: short_d = '0;
            endcase
        end
    end

    always_comb
    begin
        dec = '0;
        dec.len = 3'd2;
        if (ge2)
        begin
            if (h[1:0] != 2'b11)
            begin
                dec = short_d;
                dec.len = 3'd2;
                dec.raw = {16'd0, h};
            end
            else if (ge4)
            begin
                dec = full_d;
                dec.len = 3'd4;
                dec.raw = w;
            end
            else
                dec.raw = {16'd0, h};
        end
    end

endmodule

/* rtl/core/rvd_target.sv */
// Branch and jump target adder: pc plus sign-extended offset, address masked.
// Depends on rvd_pkg.
module rvd_target #(
    parameter int ADDRESS_WIDTH = 64
) (
    input  logic        [63:0] pc,
    input  rvd_pkg::dec_t      dec,
    output logic        [63:0] target
);
    import rvd_pkg::*;

    localparam logic [63:0] ADDR_MASK = (ADDRESS_WIDTH >= 64) ? {64{1'b1}} :
                                        ((64'd1 << ADDRESS_WIDTH) - 64'd1);

    logic [63:0] sum;

    assign sum = pc + {{32{dec.off[31]}}, dec.off};
    assign target = dec.hast ? (sum & ADDR_MASK) : 64'd0;

endmodule

/* rtl/core/rv64imc_instruction_decoder_core.sv */
// Top level of the RV64IMC decoder: three-stage valid/stall pipeline.
// Depends on rvd_pkg, rvd_decode, rvd_target, assert_macros.svh.
//
//  channel   direction  handshake                 payload
//  input     in         in_valid / in_stall       fetch_word, bytes_available, pc
//  output    out        out_valid / out_stall     valid_res .. jump_target
//  config    in         rv64_mode_we              rv64_mode_wdata
//
// Three register stages (capture, decode, target add) lie between acceptance and
// out_valid; one word per cycle sustained while out_stall is low.
// Each stage advances when it is empty or the stage after it moves; an output stall
// holds full stages up to the first empty one; in_stall rises only when all are full.
// Reset empties the pipe and clears rv64_mode to RV32.
module rv64imc_instruction_decoder_core #(
    parameter int ADDRESS_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rv64_mode_we,
    input  logic        rv64_mode_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] fetch_word,
    input  logic [2:0]  bytes_available,
    input  logic [63:0] pc,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [2:0]  insn_len,
    output logic [31:0] raw_bits,
    output logic [3:0]  format_code,
    output logic [6:0]  op_id,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src1_reg,
    output logic [4:0]  src2_reg,
    output logic signed [31:0] immediate,
    output logic        has_jump_target,
    output logic [63:0] jump_target
);
    import rvd_pkg::*;
    `include "assert_macros.svh"

    logic        mode_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;
    logic [31:0] word1_reg;
    logic [2:0]  avail1_reg;
    logic [63:0] pc1_reg, pc2_reg;
    dec_t        dec_next, dec2_reg, dec3_reg;
    logic [63:0] tgt_next, tgt3_reg;

    assign adv3 = !v3_reg || !out_stall;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_stall = !adv1;

    rvd_decode u_decode (
        .word  (word1_reg),
        .avail (avail1_reg),
        .mode  (mode_reg),
        .dec   (dec_next)
    );

    rvd_target #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_target (
        .pc     (pc2_reg),
        .dec    (dec2_reg),
        .target (tgt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rv64_mode_we)
                mode_reg <= rv64_mode_wdata;
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            word1_reg <= fetch_word;
            avail1_reg <= bytes_available;
            pc1_reg <= pc;
        end
        if (adv2 && v1_reg)
        begin
            dec2_reg <= dec_next;
            pc2_reg <= pc1_reg;
        end
        if (adv3 && v2_reg)
        begin
            dec3_reg <= dec2_reg;
            tgt3_reg <= tgt_next;
        end
    end

    assign out_valid = v3_reg;
    assign valid_res = dec3_reg.valid;
    assign insn_len = dec3_reg.len;
    assign raw_bits = dec3_reg.raw;
    assign format_code = dec3_reg.fmt;
    assign op_id = dec3_reg.op;
    assign dest_reg = dec3_reg.rd;
    assign src1_reg = dec3_reg.rs1;
    assign src2_reg = dec3_reg.rs2;
    assign immediate = dec3_reg.imm;
    assign has_jump_target = dec3_reg.hast;
    assign jump_target = tgt3_reg;

    `ASSERT_AT(a_invalid_clear, clk, rst_n,
        (out_valid && !valid_res) |-> (op_id == 7'd0 && format_code == 4'd0 && !has_jump_target),
        "invalid word carries decode fields")
    `ASSERT_AT(a_target_valid, clk, rst_n, (out_valid && has_jump_target) |-> valid_res,
        "target on unrecognized word")
    `ASSERT_AT(a_full_len, clk, rst_n,
        (out_valid && insn_len == 3'd4) |-> (raw_bits[1:0] == 2'b11),
        "full length on compressed encoding")
    `ASSERT_NEXT(a_hold, clk, rst_n, v3_reg && out_stall && v2_reg, v3_reg && v2_reg,
        "stalled pipe lost a word")

endmodule

/* verif/rv64imc_instruction_decoder_core_tb.sv */
// Self-checking bench for rv64imc_instruction_decoder_core: directed and random fetch words.
// Decoder behavior is predicted in the bench itself; depends on rvd_pkg and the DUT.
`timescale 1ns / 100ps

module rv64imc_instruction_decoder_core_tb;
    import rvd_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  avail;
        logic [63:0] pc;
    } fetch_t;

    typedef struct {
        logic        valid;
        logic [2:0]  len;
        logic [31:0] raw;
        fmt_t        fmt;
        op_t         op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        hast;
        logic [63:0] tgt;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        rv64_mode_we;
    logic        rv64_mode_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] fetch_word;
    logic [2:0]  bytes_available;
    logic [63:0] pc;
    logic        out_valid;
    logic        out_stall;
    logic        valid_res;
    logic [2:0]  insn_len;
    logic [31:0] raw_bits;
    logic [3:0]  format_code;
    logic [6:0]  op_id;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic signed [31:0] immediate;
    logic        has_jump_target;
    logic [63:0] jump_target;

    rv64imc_instruction_decoder_core #(.ADDRESS_WIDTH(64)) dut (
        .clk(clk), .rst_n(rst_n),
        .rv64_mode_we(rv64_mode_we), .rv64_mode_wdata(rv64_mode_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .fetch_word(fetch_word), .bytes_available(bytes_available), .pc(pc),
        .out_valid(out_valid), .out_stall(out_stall),
        .valid_res(valid_res), .insn_len(insn_len), .raw_bits(raw_bits),
        .format_code(format_code), .op_id(op_id), .dest_reg(dest_reg),
        .src1_reg(src1_reg), .src2_reg(src2_reg), .immediate(immediate),
        .has_jump_target(has_jump_target), .jump_target(jump_target)
    );

    fetch_t   fetch_q[$];
    decoded_t decoded_q[$];
    logic     mode64;
    int       mismatches;
    int       words_sent;
    int       words_checked;
    int       idle_cycles;
    int       send_gap;
    int       recv_gap;
    bit       feed_hold;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = 32'd1 << (bits - 1);
        return ((v & ((m << 1) - 32'd1)) ^ m) - m;
    endfunction

    function automatic void set_dec(inout decoded_t d, input fmt_t f, input op_t o,
                                    input logic [4:0] rd, input logic [4:0] rs1,
                                    input logic [4:0] rs2, input logic [31:0] imm);
        d.valid = 1'b1; d.fmt = f; d.op = o;
        d.rd = rd; d.rs1 = rs1; d.rs2 = rs2; d.imm = imm;
    endfunction

    function automatic void set_target(inout decoded_t d, input logic [63:0] base,
                                       input logic [31:0] off);
        d.hast = 1'b1;
        d.tgt = base + {{32{off[31]}}, off};
    endfunction

    function automatic void decode_full(inout decoded_t d, input logic [31:0] w,
                                        input logic [63:0] base);
        logic [6:0]  opc, f7, top, sra_top;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [31:0] immi, imms, immb, immj, sh;
        opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
        f7 = w[31:25];
        immi = sx({20'd0, w[31:20]}, 12);
        imms = sx({20'd0, w[31:25], w[11:7]}, 12);
        immb = sx({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        immj = sx({11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
        sh = mode64 ? {26'd0, w[25:20]} : {27'd0, w[24:20]};
        top = mode64 ? {1'b0, w[31:26]} : f7;
        sra_top = mode64 ? F6_ALT64 : F7_ALT;
        case (opc)
            OPC_LUI: set_dec(d, F_U, O_LUI, rd, 0, 0, {12'd0, w[31:12]});
            OPC_AUIPC: set_dec(d, F_U, O_AUIPC, rd, 0, 0, {12'd0, w[31:12]});
            OPC_JAL:
            begin
                set_dec(d, F_J, O_JAL, rd, 0, 0, immj);
                set_target(d, base, immj);
            end
            OPC_JALR: if (f3 == 3'd0) set_dec(d, F_I, O_JALR, rd, rs1, 0, immi);
            OPC_BRANCH:
            begin
                op_t o;
                case (f3)
                    3'd0: o = O_BEQ;
                    3'd1: o = O_BNE;
                    3'd4: o = O_BLT;
                    3'd5: o = O_BGE;
                    3'd6: o = O_BLTU;
                    3'd7: o = O_BGEU;
                    default: o = O_NONE;
                endcase
                if (o != O_NONE)
                begin
                    set_dec(d, F_B, o, 0, rs1, rs2, immb);
                    set_target(d, base, immb);
                end
            end
            OPC_LOAD:
            begin
                op_t o;
                case (f3)
                    3'd0: o = O_LB;
                    3'd1: o = O_LH;
                    3'd2: o = O_LW;
                    3'd3: o = mode64 ? O_LD : O_NONE;
                    3'd4: o = O_LBU;
                    3'd5: o = O_LHU;
                    3'd6: o = mode64 ? O_LWU : O_NONE;
                    default: o = O_NONE;
                endcase
                if (o != O_NONE) set_dec(d, F_I, o, rd, rs1, 0, immi);
            end
            OPC_STORE:
            begin
                op_t o;
                case (f3)
                    3'd0: o = O_SB;
                    3'd1: o = O_SH;
                    3'd2: o = O_SW;
                    3'd3: o = mode64 ? O_SD : O_NONE;
                    default: o = O_NONE;
                endcase
                if (o != O_NONE) set_dec(d, F_S, o, 0, rs1, rs2, imms);
            end
            OPC_OPIMM:
            begin
                case (f3)
                    3'd1: if (top == 7'd0) set_dec(d, F_I, O_SLLI, rd, rs1, 0, sh);
                    3'd5:
                        if (top == 7'd0) set_dec(d, F_I, O_SRLI, rd, rs1, 0, sh);
                        else if (top == sra_top) set_dec(d, F_I, O_SRAI, rd, rs1, 0, sh);
                    3'd0: set_dec(d, F_I, O_ADDI, rd, rs1, 0, immi);
                    3'd2: set_dec(d, F_I, O_SLTI, rd, rs1, 0, immi);
                    3'd3: set_dec(d, F_I, O_SLTIU, rd, rs1, 0, immi);
                    3'd4: set_dec(d, F_I, O_XORI, rd, rs1, 0, immi);
                    3'd6: set_dec(d, F_I, O_ORI, rd, rs1, 0, immi);
                    default: set_dec(d, F_I, O_ANDI, rd, rs1, 0, immi);
                endcase
            end
            OPC_OP:
            begin
                if (f7 == F7_MULDIV)
                    set_dec(d, F_R, op_t'(O_MUL + f3), rd, rs1, rs2, 0);
                else if (f7 == F7_ZERO)
                begin
                    op_t o;
                    case (f3)
                        3'd0: o = O_ADD;
                        3'd1: o = O_SLL;
                        3'd2: o = O_SLT;
                        3'd3: o = O_SLTU;
                        3'd4: o = O_XOR;
                        3'd5: o = O_SRL;
                        3'd6: o = O_OR;
                        default: o = O_AND;
                    endcase
                    set_dec(d, F_R, o, rd, rs1, rs2, 0);
                end
                else if (f7 == F7_ALT && f3 == 3'd0) set_dec(d, F_R, O_SUB, rd, rs1, rs2, 0);
                else if (f7 == F7_ALT && f3 == 3'd5) set_dec(d, F_R, O_SRA, rd, rs1, rs2, 0);
            end
            OPC_OPIMMW:
                if (mode64)
                begin
                    if (f3 == 3'd0) set_dec(d, F_I, O_ADDIW, rd, rs1, 0, immi);
                    else if (f3 == 3'd1 && f7 == F7_ZERO)
                        set_dec(d, F_I, O_SLLIW, rd, rs1, 0, rs2);
                    else if (f3 == 3'd5 && f7 == F7_ZERO)
                        set_dec(d, F_I, O_SRLIW, rd, rs1, 0, rs2);
                    else if (f3 == 3'd5 && f7 == F7_ALT)
                        set_dec(d, F_I, O_SRAIW, rd, rs1, 0, rs2);
                end
            OPC_OPW:
                if (mode64)
                begin
                    if (f7 == F7_MULDIV)
                    begin
                        if (f3 == 3'd0) set_dec(d, F_R, O_MULW, rd, rs1, rs2, 0);
                        else if (f3 >= 3'd4)
                            set_dec(d, F_R, op_t'(O_DIVW + f3 - 3'd4), rd, rs1, rs2, 0);
                    end
                    else if (f7 == F7_ZERO && f3 == 3'd0) set_dec(d, F_R, O_ADDW, rd, rs1, rs2, 0);
                    else if (f7 == F7_ZERO && f3 == 3'd1) set_dec(d, F_R, O_SLLW, rd, rs1, rs2, 0);
                    else if (f7 == F7_ZERO && f3 == 3'd5) set_dec(d, F_R, O_SRLW, rd, rs1, rs2, 0);
                    else if (f7 == F7_ALT && f3 == 3'd0) set_dec(d, F_R, O_SUBW, rd, rs1, rs2, 0);
                    else if (f7 == F7_ALT && f3 == 3'd5) set_dec(d, F_R, O_SRAW, rd, rs1, rs2, 0);
                end
            OPC_FENCE:
                if (f3 == 3'd0)
                    set_dec(d, F_I, O_FENCE, 0, 0, 0, {24'd0, w[27:24], w[23:20]});
                else if (f3 == 3'd1) set_dec(d, F_I, O_FENCE_I, 0, 0, 0, 0);
            OPC_SYSTEM:
                if (f3 == 3'd0 && rs1 == 5'd0 && rd == 5'd0)
                begin
                    if (w[31:20] == 12'd0) set_dec(d, F_I, O_ECALL, 0, 0, 0, 0);
                    else if (w[31:20] == 12'd1) set_dec(d, F_I, O_EBREAK, 0, 0, 0, 0);
                end
            default: ;
        endcase
    endfunction

    function automatic void decode_compressed(inout decoded_t d, input logic [15:0] h,
                                              input logic [63:0] base);
        logic [2:0]  f3;
        logic [4:0]  rd, rs2, rdp, rs1p;
        logic [5:0]  six;
        logic [31:0] ci, joff, lw_off, ld_off, u;
        logic [1:0]  f2, f6;
        f3 = h[15:13]; rd = h[11:7]; rs2 = h[6:2];
        rdp = {2'b01, h[4:2]}; rs1p = {2'b01, h[9:7]};
        six = {h[12], h[6:2]};
        ci = sx({26'd0, six}, 6);
        joff = sx({20'd0, h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0}, 12);
        lw_off = {25'd0, h[5], h[12:10], h[6], 2'b00};
        ld_off = {24'd0, h[6:5], h[12:10], 3'b000};
        if (h == 16'd0) return;
        case (h[1:0])
            2'd0:
                case (f3)
                    3'd0:
                    begin
                        u = {22'd0, h[10:7], h[12:11], h[5], h[6], 2'b00};
                        if (u != 0) set_dec(d, F_CIW, O_C_ADDI4SPN, rdp, 2, 0, u);
                    end
                    3'd2: set_dec(d, F_CL, O_C_LW, rdp, rs1p, 0, lw_off);
                    3'd3: if (mode64) set_dec(d, F_CL, O_C_LD, rdp, rs1p, 0, ld_off);
                    3'd6: set_dec(d, F_CS, O_C_SW, 0, rs1p, rdp, lw_off);
                    3'd7: if (mode64) set_dec(d, F_CS, O_C_SD, 0, rs1p, rdp, ld_off);
                    default: ;
                endcase
            2'd1:
                case (f3)
                    3'd0:
                        if (rd == 0 && six == 0) set_dec(d, F_CI, O_C_NOP, 0, 0, 0, 0);
                        else if (rd != 0 && six != 0) set_dec(d, F_CI, O_C_ADDI, rd, rd, 0, ci);
                    3'd1:
                        if (mode64)
                        begin
                            if (rd != 0) set_dec(d, F_CI, O_C_ADDIW, rd, rd, 0, ci);
                        end
                        else
                        begin
                            set_dec(d, F_CJ, O_C_JAL, 1, 0, 0, joff);
                            set_target(d, base, joff);
                        end
                    3'd2: if (rd != 0) set_dec(d, F_CI, O_C_LI, rd, 0, 0, ci);
                    3'd3:
                        if (rd == 5'd2)
                        begin
                            u = {22'd0, h[12], h[4:3], h[5], h[2], h[6], 4'd0};
                            if (u != 0) set_dec(d, F_CI, O_C_ADDI16SP, 2, 2, 0, sx(u, 10));
                        end
                        else if (rd != 0 && six != 0)
                            set_dec(d, F_CI, O_C_LUI, rd, 0, 0, ci & 32'hfffff);
                    3'd4:
                    begin
                        f2 = h[11:10]; f6 = h[6:5];
                        if (f2 < 2)
                        begin
                            if (six != 0 && (mode64 || !h[12]))
                                set_dec(d, F_CB, f2[0] ? O_C_SRAI : O_C_SRLI, rs1p, rs1p, 0,
                                        {26'd0, six});
                        end
                        else if (f2 == 2) set_dec(d, F_CB, O_C_ANDI, rs1p, rs1p, 0, ci);
                        else if (!h[12]) set_dec(d, F_CS, op_t'(O_C_SUB + f6), rs1p, rs1p, rdp, 0);
                        else if (mode64 && f6 < 2)
                            set_dec(d, F_CS, f6[0] ? O_C_ADDW : O_C_SUBW, rs1p, rs1p, rdp, 0);
                    end
                    3'd5:
                    begin
                        set_dec(d, F_CJ, O_C_J, 0, 0, 0, joff);
                        set_target(d, base, joff);
                    end
                    default:
                    begin
                        u = sx({23'd0, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0}, 9);
                        set_dec(d, F_CB, f3 == 3'd6 ? O_C_BEQZ : O_C_BNEZ, 0, rs1p, 0, u);
                        set_target(d, base, u);
                    end
                endcase
            2'd2:
                case (f3)
                    3'd0:
                        if (rd != 0 && six != 0 && (mode64 || !h[12]))
                            set_dec(d, F_CI, O_C_SLLI, rd, rd, 0, {26'd0, six});
                    3'd2:
                        if (rd != 0)
                            set_dec(d, F_CI, O_C_LWSP, rd, 2, 0,
                                    {24'd0, h[3:2], h[12], h[6:4], 2'b00});
                    3'd3:
                        if (mode64 && rd != 0)
                            set_dec(d, F_CI, O_C_LDSP, rd, 2, 0,
                                    {23'd0, h[4:2], h[12], h[6:5], 3'b000});
                    3'd4:
                        if (!h[12])
                        begin
                            if (rd != 0)
                            begin
                                if (rs2 == 0) set_dec(d, F_CR, O_C_JR, 0, rd, 0, 0);
                                else set_dec(d, F_CR, O_C_MV, rd, 0, rs2, 0);
                            end
                        end
                        else if (rd == 0)
                        begin
                            if (rs2 == 0) set_dec(d, F_CR, O_C_EBREAK, 0, 0, 0, 0);
                        end
                        else if (rs2 == 0) set_dec(d, F_CR, O_C_JALR, 1, rd, 0, 0);
                        else set_dec(d, F_CR, O_C_ADD, rd, rd, rs2, 0);
                    3'd6:
                        set_dec(d, F_CSS, O_C_SWSP, 0, 2, rs2, {24'd0, h[8:7], h[12:9], 2'b00});
                    3'd7:
                        if (mode64)
                            set_dec(d, F_CSS, O_C_SDSP, 0, 2, rs2,
                                    {23'd0, h[9:7], h[12:10], 3'b000});
                    default: ;
                endcase
            default: ;
        endcase
    endfunction

    function automatic decoded_t predict_decode(input fetch_t f);
        decoded_t d;
        d = '{valid: 1'b0, len: 3'd2, raw: 32'd0, fmt: F_UNK, op: O_NONE, rd: 5'd0,
              rs1: 5'd0, rs2: 5'd0, imm: 32'd0, hast: 1'b0, tgt: 64'd0};
        if (f.avail >= 3'd2)
        begin
            d.raw = {16'd0, f.word[15:0]};
            if (f.word[1:0] != 2'b11) decode_compressed(d, f.word[15:0], f.pc);
            else if (f.avail >= 3'd4)
            begin
                d.len = 3'd4;
                d.raw = f.word;
                decode_full(d, f.word, f.pc);
            end
        end
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on word %0d: %s got %h want %h", words_checked, what, got, want);
        mismatches++;
    endtask

    task automatic push_word(input logic [31:0] w, input logic [2:0] a, input logic [63:0] p);
        fetch_t f;
        f.word = w; f.avail = a; f.pc = p;
        fetch_q.push_back(f);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            fetch_word <= 32'd0;
            bytes_available <= 3'd0;
            pc <= 64'd0;
            send_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                decoded_q.push_back(predict_decode('{fetch_word, bytes_available, pc}));
            if (in_valid)
                words_sent++;
            if (send_gap > 0 || feed_hold || fetch_q.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end
            else
            begin
                fetch_t f;
                f = fetch_q.pop_front();
                in_valid <= 1'b1;
                fetch_word <= f.word;
                bytes_available <= f.avail;
                pc <= f.pc;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch("unexpected word", 64'd0, 64'd0);
                else
                begin
                    decoded_t e;
                    e = decoded_q.pop_front();
                    if (valid_res !== e.valid) report_mismatch("valid_res", valid_res, e.valid);
                    if (insn_len !== e.len) report_mismatch("insn_len", insn_len, e.len);
                    if (raw_bits !== e.raw) report_mismatch("raw_bits", raw_bits, e.raw);
                    if (format_code !== e.fmt) report_mismatch("format_code", format_code, e.fmt);
                    if (op_id !== e.op) report_mismatch("op_id", op_id, e.op);
                    if (dest_reg !== e.rd) report_mismatch("dest_reg", dest_reg, e.rd);
                    if (src1_reg !== e.rs1) report_mismatch("src1_reg", src1_reg, e.rs1);
                    if (src2_reg !== e.rs2) report_mismatch("src2_reg", src2_reg, e.rs2);
                    if (immediate !== e.imm) report_mismatch("immediate", immediate, e.imm);
                    if (has_jump_target !== e.hast)
                        report_mismatch("has_jump_target", has_jump_target, e.hast);
                    if (jump_target !== e.tgt)
                        report_mismatch("jump_target", jump_target, e.tgt);
                    words_checked++;
                end
            end
            if (recv_gap > 0)
            begin
                out_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end
            else if (out_valid && !out_stall)
            begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles > 2000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic drain();
        while (fetch_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        rv64_mode_we <= 1'b1;
        rv64_mode_wdata <= m;
        @(posedge clk);
        rv64_mode_we <= 1'b0;
        mode64 = m;
    endtask

    function automatic logic [31:0] well_formed_word();
        logic [31:0] w;
        logic [6:0]  opcs[13];
        opcs = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
                 OPC_OPIMM, OPC_OP, OPC_OPIMMW, OPC_OPW, OPC_FENCE, OPC_SYSTEM};
        w = $urandom;
        case ($urandom_range(0, 5))
            0, 1, 2:
            begin
                w[6:0] = opcs[$urandom_range(0, 12)];
                if (w[6:0] == OPC_OP || w[6:0] == OPC_OPW)
                    w[31:25] = ($urandom_range(0, 2) == 0) ? F7_MULDIV :
                               ($urandom_range(0, 1) ? F7_ZERO : F7_ALT);
                else if (w[6:0] == OPC_OPIMM || w[6:0] == OPC_OPIMMW)
                    w[31:25] = $urandom_range(0, 1) ? F7_ZERO : F7_ALT;
                else if (w[6:0] == OPC_SYSTEM)
                begin
                    w[19:7] = 13'd0;
                    w[31:20] = 12'($urandom_range(0, 2));
                end
            end
            3: w[1:0] = 2'($urandom_range(0, 2));
            4:
            begin
                w[1:0] = 2'($urandom_range(0, 2));
                w[15:13] = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 1)) w[11:7] = 5'($urandom_range(0, 2));
                if ($urandom_range(0, 1)) w[6:2] = 5'd0;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_burst(input int n);
        logic [63:0] p;
        logic [2:0]  a;
        for (int i = 0; i < n; i++)
        begin
            p = {$urandom, $urandom};
            a = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            push_word(well_formed_word(), a, p);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        rv64_mode_we = 1'b0;
        rv64_mode_wdata = 1'b0;
        mode64 = 1'b0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        feed_hold = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed, RV32 after reset
        push_word(32'h0000_0000, 3'd0, 64'd0);
        push_word(32'hffff_ffff, 3'd1, 64'hffff_ffff_ffff_ffff);
        push_word(32'hffff_ffff, 3'd3, 64'd0);
        push_word(32'h0000_0000, 3'd2, 64'd0);
        push_word(32'hffff_f06f, 3'd4, 64'd0);
        push_word(32'h8000_0063, 3'd7, 64'h0000_0000_0000_0010);
        push_word(32'h0000_0073, 3'd5, 64'd0);
        push_word(32'h0010_0073, 3'd6, 64'd0);
        push_word(32'h0ff0_000f, 3'd4, 64'd0);
        push_word(32'h4000_5013, 3'd4, 64'd0);
        push_word(32'h0000_2001, 3'd2, 64'hffff_ffff_ffff_fffe);
        push_word(32'h0000_0001, 3'd2, 64'd0);
        push_word(32'h0000_0005, 3'd2, 64'd0);
        push_word(32'h0000_6101, 3'd2, 64'd0);
        push_word(32'h0000_7141, 3'd2, 64'd0);
        push_word(32'h0000_9002, 3'd2, 64'd0);
        push_word(32'h0000_8082, 3'd2, 64'd0);
        push_word(32'h0000_1002, 3'd2, 64'd0);
        drain();
        write_mode(1'b1);
        push_word(32'h0000_3003, 3'd4, 64'd0);
        push_word(32'h4200_5013, 3'd4, 64'd0);
        push_word(32'h0000_2001, 3'd2, 64'd0);
        push_word(32'h0000_9c21, 3'd2, 64'd0);
        push_word(32'h0000_e000, 3'd2, 64'd0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0]);
            random_burst(130);
            // pause the feed until the pipe is empty
            repeat (40) @(posedge clk);
            feed_hold = 1'b1;
            while (decoded_q.size() != 0 || in_valid) @(posedge clk);
            feed_hold = 1'b0;
            drain();
        end
        $display("%0d words sent, %0d decoded and checked over both modes, directed and random",
                 words_sent, words_checked);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
